// File: src/rucic_pkg.sv
// Package with the item types, address decodes and field widths of the IRQ counter.
package rucic_pkg;

  localparam int unsigned NibbleW  = 4;
  localparam int unsigned DataW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned BankW    = 8;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  localparam logic [NibbleW-1:0] ADDR_RELOAD0 = 4'h8;
  localparam logic [NibbleW-1:0] ADDR_RELOAD1 = 4'h9;
  localparam logic [NibbleW-1:0] ADDR_RELOAD2 = 4'hA;
  localparam logic [NibbleW-1:0] ADDR_RELOAD3 = 4'hB;
  localparam logic [NibbleW-1:0] ADDR_CONTROL = 4'hC;
  localparam logic [NibbleW-1:0] ADDR_ACK     = 4'hD;
  localparam logic [NibbleW-1:0] ADDR_BANK    = 4'hF;

  typedef struct packed {
    logic               kind;
    logic [NibbleW-1:0] addr_nibble;
    logic [DataW-1:0]   wdata;
  } item_t;

  typedef struct packed {
    logic              irq;
    logic [BankW-1:0]  prg_bank;
    logic [CountW-1:0] count_value;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } slot_t;

endpackage

// File: src/rucic_ifs.sv
// Valid/ready channel interfaces for the input words and the result words.
interface rucic_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [rucic_pkg::NibbleW-1:0]     addr_nibble;
  logic [rucic_pkg::DataW-1:0]       wdata;

  modport source (output valid, output kind, output addr_nibble, output wdata, input ready);
  modport sink   (input valid, input kind, input addr_nibble, input wdata, output ready);
endinterface

interface rucic_out_if;
  logic                              valid;
  logic                              ready;
  logic                              irq;
  logic [rucic_pkg::BankW-1:0]       prg_bank;
  logic [rucic_pkg::CountW-1:0]      count_value;

  modport source (output valid, output irq, output prg_bank, output count_value, input ready);
  modport sink   (input valid, input irq, input prg_bank, input count_value, output ready);
endinterface

// File: src/rucic_in_stage.sv
// Input register that holds one accepted word until the core consumes it.
module rucic_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  rucic_in_if.sink             in_ch,
  input  logic                 take,
  output rucic_pkg::slot_t     slot
);

  logic              valid_r;
  logic              valid_nxt;
  rucic_pkg::item_t  item_r;

  assign in_ch.ready = !valid_r || take;
  assign valid_nxt   = in_ch.valid || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.kind        <= in_ch.kind;
      item_r.addr_nibble <= in_ch.addr_nibble;
      item_r.wdata       <= in_ch.wdata;
    end
  end

  assign slot.valid = valid_r;
  assign slot.item  = item_r;

endmodule

// File: src/rucic_core.sv
// Counter, reload latch, control bits and bank register with their next-state logic.
module rucic_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  rucic_pkg::item_t     item,
  output rucic_pkg::result_t   result
);

  logic [rucic_pkg::CountW-1:0] latch_r, latch_nxt;
  logic [rucic_pkg::CountW-1:0] counter_r, counter_nxt;
  logic                         mode8_r, mode8_nxt;
  logic                         enable_r, enable_nxt;
  logic                         ack_enable_r, ack_enable_nxt;
  logic [rucic_pkg::BankW-1:0]  bank_r, bank_nxt;
  logic                         irq_r, irq_nxt;

  always_comb begin
    latch_nxt      = latch_r;
    counter_nxt    = counter_r;
    mode8_nxt      = mode8_r;
    enable_nxt     = enable_r;
    ack_enable_nxt = ack_enable_r;
    bank_nxt       = bank_r;
    irq_nxt        = irq_r;
    if (item.kind == rucic_pkg::KIND_TICK) begin
      if (enable_r) begin
        if (mode8_r) begin
          if (counter_r[7:0] == 8'hFF) begin
            counter_nxt = {counter_r[15:8], latch_r[7:0]};
            irq_nxt     = 1'b1;
          end else begin
            counter_nxt = {counter_r[15:8], counter_r[7:0] + 8'd1};
          end
        end else begin
          if (counter_r == 16'hFFFF) begin
            counter_nxt = latch_r;
            irq_nxt     = 1'b1;
          end else begin
            counter_nxt = counter_r + 16'd1;
          end
        end
      end
    end else begin
      case (item.addr_nibble)
        rucic_pkg::ADDR_RELOAD0: latch_nxt[3:0]   = item.wdata[3:0];
        rucic_pkg::ADDR_RELOAD1: latch_nxt[7:4]   = item.wdata[3:0];
        rucic_pkg::ADDR_RELOAD2: latch_nxt[11:8]  = item.wdata[3:0];
        rucic_pkg::ADDR_RELOAD3: latch_nxt[15:12] = item.wdata[3:0];
        rucic_pkg::ADDR_CONTROL: begin
          mode8_nxt      = item.wdata[2];
          enable_nxt     = item.wdata[1];
          ack_enable_nxt = item.wdata[0];
          if (item.wdata[1]) begin
            counter_nxt = latch_r;
          end
          irq_nxt = 1'b0;
        end
        rucic_pkg::ADDR_ACK: begin
          irq_nxt    = 1'b0;
          enable_nxt = ack_enable_r;
        end
        rucic_pkg::ADDR_BANK: bank_nxt = item.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r      <= '0;
      counter_r    <= '0;
      mode8_r      <= 1'b0;
      enable_r     <= 1'b0;
      ack_enable_r <= 1'b0;
      bank_r       <= '0;
      irq_r        <= 1'b0;
    end else if (step) begin
      latch_r      <= latch_nxt;
      counter_r    <= counter_nxt;
      mode8_r      <= mode8_nxt;
      enable_r     <= enable_nxt;
      ack_enable_r <= ack_enable_nxt;
      bank_r       <= bank_nxt;
      irq_r        <= irq_nxt;
    end
  end

  assign result.irq         = irq_nxt;
  assign result.prg_bank    = bank_nxt;
  assign result.count_value = counter_nxt;

endmodule

// File: src/rucic_out_stage.sv
// Result register that holds one word until the receiver takes it.
module rucic_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pending,
  input  rucic_pkg::result_t   result,
  output logic                 take,
  rucic_out_if.source          out_ch
);

  logic                valid_r;
  logic                valid_nxt;
  rucic_pkg::result_t  result_r;

  assign take      = pending && (!valid_r || out_ch.ready);
  assign valid_nxt = take || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.irq         = result_r.irq;
  assign out_ch.prg_bank    = result_r.prg_bank;
  assign out_ch.count_value = result_r.count_value;

endmodule

// File: src/reload_up_counter_irq_with_bank.sv
// Top level of the reloading up-counter with interrupt and program bank register.
//
// Each input word is either a CPU bus write (kind 0, decoded by address bits 15..12)
// or one CPU cycle tick (kind 1). Every input word gives exactly one result word
// carrying the interrupt line level, the program bank and the counter value after
// that word has been applied.
//
// An accepted word is captured in the input register. Once the output register can
// take a result, the word is applied to the counter state and its result word is
// captured, at the same edge, in the output register that drives the result channel.
// The update is combinational: while results are taken, one word is accepted per cycle.
//
// When the receiver stalls, the result word holds in the output register and the
// input register still takes one more word; after that in_ch.ready falls until the
// result is taken. No word is dropped or repeated.
//
// A synchronous, active-low reset clears the counter, the reload latch, the control
// bits, the bank register and the interrupt, and empties both registers.
module reload_up_counter_irq_with_bank (
  input  logic        clk,
  input  logic        rst_n,
  rucic_in_if.sink    in_ch,
  rucic_out_if.source out_ch
);

  rucic_pkg::slot_t    slot;
  rucic_pkg::result_t  result;
  logic                take;

  rucic_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .slot  (slot)
  );

  rucic_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (take),
    .item   (slot.item),
    .result (result)
  );

  rucic_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .pending (slot.valid),
    .result  (result),
    .take    (take),
    .out_ch  (out_ch)
  );

endmodule
